// ===== design/slpt_pkg.sv =====
package slpt_pkg;

   localparam int ENTRIES  = 16;
   localparam int KEY_BITS = 32;
   localparam int IDX_BITS = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int ENT_BITS = KEY_BITS + 128;

   localparam logic [IDX_BITS-1:0] IDX_LAST = IDX_BITS'(ENTRIES - 1);
   localparam logic [4:0]          CNT_MAX  = 5'd31;

   localparam logic [2:0] CMD_PIN      = 3'd0;
   localparam logic [2:0] CMD_RELEASE  = 3'd1;
   localparam logic [2:0] CMD_LOOKUP   = 3'd2;
   localparam logic [2:0] CMD_FLOOR    = 3'd3;
   localparam logic [2:0] CMD_ISPINNED = 3'd4;
   localparam logic [2:0] CMD_EVICT    = 3'd5;

   typedef struct packed {
      logic [KEY_BITS-1:0] key;
      logic [63:0]         revision;
      logic [63:0]         deadline;
   } entry_type;

   // Control from the sequencer to the per-entry evaluation unit.
   typedef struct packed {
      logic                start;
      logic                check;
      logic [IDX_BITS-1:0] idx;
      logic                valid;
   } scan_ctl_type;

   typedef struct packed {
      logic                found;
      logic [IDX_BITS-1:0] found_idx;
      logic [63:0]         found_rev;
      logic [63:0]         found_dl;
      logic                free;
      logic [IDX_BITS-1:0] free_idx;
      logic [63:0]         floor_rev;
      logic                pinned;
      logic [4:0]          expired;
   } scan_res_type;

   function automatic logic [KEY_BITS-1:0] key_of(input logic [31:0] raw);
      logic [63:0] wide;
      wide = {32'd0, raw};
      return wide[KEY_BITS-1:0];
   endfunction

endpackage

// ===== design/slpt_ram.sv =====
module slpt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                         clock,
   input  logic                                         wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                             wr_data,
   input  logic                                         rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                             rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/slpt_scan.sv =====
module slpt_scan (
   input  logic                          clock,
   input  slpt_pkg::scan_ctl_type        ctl,
   input  slpt_pkg::entry_type           entry,
   input  logic [slpt_pkg::KEY_BITS-1:0] key,
   input  logic [63:0]                   revision,
   input  logic [63:0]                   now_time,
   output logic                          expire,
   output slpt_pkg::scan_res_type        res
);

   slpt_pkg::scan_res_type res_ff;
   slpt_pkg::scan_res_type res_in;
   logic                   live;

   assign live   = now_time < entry.deadline;
   assign expire = ctl.check && ctl.valid && !live;

   always_comb begin
      res_in = res_ff;
      if (ctl.start) begin
         res_in.found     = 1'b0;
         res_in.found_idx = '0;
         res_in.found_rev = '0;
         res_in.found_dl  = '0;
         res_in.free      = 1'b0;
         res_in.free_idx  = '0;
         res_in.floor_rev = '1;
         res_in.pinned    = 1'b0;
         res_in.expired   = '0;
      end else if (ctl.check) begin
         if (ctl.valid && entry.key == key && !res_ff.found) begin
            res_in.found     = 1'b1;
            res_in.found_idx = ctl.idx;
            res_in.found_rev = entry.revision;
            res_in.found_dl  = entry.deadline;
         end
         if (!ctl.valid && !res_ff.free) begin
            res_in.free     = 1'b1;
            res_in.free_idx = ctl.idx;
         end
         if (ctl.valid && live && entry.revision < res_ff.floor_rev) begin
            res_in.floor_rev = entry.revision;
         end
         if (ctl.valid && live && entry.revision <= revision) begin
            res_in.pinned = 1'b1;
         end
         if (ctl.valid && !live && res_ff.expired != slpt_pkg::CNT_MAX) begin
            res_in.expired = res_ff.expired + 5'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      res_ff <= res_in;
   end

   assign res = res_ff;

endmodule

// ===== design/snapshot_lease_pin_table.sv =====
// Channel   Direction  Handshake             Payload
// req_      in         req_valid/req_stall   command, key, revision, deadline, now
// rsp_      out        rsp_valid/rsp_stall   hit, revision, deadline, removed, full
//
// Every request walks the whole entry memory, one entry read per cycle, and
// the next request is not taken until the previous one has loaded its
// response. The single read port of the entry memory makes the walk serial.
// Synchronous reset empties the table at once through the valid flops.
// A finished response waits in its register while the next request is taken;
// a request only stalls at its final step if that response is still held.
module snapshot_lease_pin_table (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_command,
   input  logic [31:0] req_holder_key,
   input  logic [63:0] req_revision_in,
   input  logic [63:0] req_deadline_in,
   input  logic [63:0] req_now_time,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_hit,
   output logic [63:0] rsp_revision_out,
   output logic [63:0] rsp_deadline_out,
   output logic [4:0]  rsp_removed_count,
   output logic        rsp_table_full
);

   typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DRAIN, S_FIN} state_type;

   state_type                             state_ff;
   logic [slpt_pkg::IDX_BITS-1:0]         cnt_ff;
   logic                                  chk_ff;
   logic [slpt_pkg::IDX_BITS-1:0]         chk_idx_ff;
   logic [slpt_pkg::ENTRIES-1:0]          valid_ff;
   logic [slpt_pkg::ENTRIES-1:0]          valid_in;
   logic [2:0]                            cmd_ff;
   logic [slpt_pkg::KEY_BITS-1:0]         key_ff;
   logic [63:0]                           rev_ff;
   logic [63:0]                           dl_ff;
   logic [63:0]                           now_ff;
   logic                                  rsp_valid_ff;
   logic                                  hit_ff;
   logic [63:0]                           rev_out_ff;
   logic [63:0]                           dl_out_ff;
   logic [4:0]                            removed_ff;
   logic                                  full_ff;

   logic                                  accept;
   logic                                  finish;
   logic                                  expire;
   logic                                  wr_en;
   logic [slpt_pkg::IDX_BITS-1:0]         wr_idx;
   slpt_pkg::entry_type                   wr_entry;
   slpt_pkg::entry_type                   rd_entry;
   slpt_pkg::scan_ctl_type                ctl;
   slpt_pkg::scan_res_type                res;
   logic                                  hit_in;
   logic [63:0]                           rev_out_in;
   logic [63:0]                           dl_out_in;
   logic [4:0]                            removed_in;
   logic                                  full_in;

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;
   // The last step loads the response register, so it waits for it to drain.
   assign finish    = (state_ff == S_FIN) && !(rsp_valid_ff && rsp_stall);

   assign ctl.start = accept;
   assign ctl.check = chk_ff;
   assign ctl.idx   = chk_idx_ff;
   assign ctl.valid = valid_ff[chk_idx_ff];

   slpt_ram #(
      .WIDTH (slpt_pkg::ENT_BITS),
      .DEPTH (slpt_pkg::ENTRIES)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_idx),
      .wr_data (wr_entry),
      .rd_en   (state_ff == S_SCAN),
      .rd_addr (cnt_ff),
      .rd_data (rd_entry)
   );

   slpt_scan u_scan (
      .clock    (clock),
      .ctl      (ctl),
      .entry    (rd_entry),
      .key      (key_ff),
      .revision (rev_ff),
      .now_time (now_ff),
      .expire   (expire),
      .res      (res)
   );

   assign wr_entry.key      = key_ff;
   assign wr_entry.revision = rev_ff;
   assign wr_entry.deadline = dl_ff;
   assign wr_idx            = res.found ? res.found_idx : res.free_idx;
   assign wr_en             = finish && (cmd_ff == slpt_pkg::CMD_PIN) &&
                              (res.found || res.free);

   always_comb begin
      hit_in     = 1'b0;
      rev_out_in = '0;
      dl_out_in  = '0;
      removed_in = '0;
      full_in    = 1'b0;
      case (cmd_ff)
         slpt_pkg::CMD_PIN: begin
            full_in = !res.found && !res.free;
         end
         slpt_pkg::CMD_RELEASE: begin
            hit_in = res.found;
         end
         slpt_pkg::CMD_LOOKUP: begin
            hit_in = res.found;
            if (res.found) begin
               rev_out_in = res.found_rev;
               dl_out_in  = res.found_dl;
            end
         end
         slpt_pkg::CMD_FLOOR: begin
            rev_out_in = res.floor_rev;
         end
         slpt_pkg::CMD_ISPINNED: begin
            hit_in = res.pinned;
         end
         slpt_pkg::CMD_EVICT: begin
            removed_in = res.expired;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      valid_in = valid_ff;
      if (expire && cmd_ff == slpt_pkg::CMD_EVICT) begin
         valid_in[chk_idx_ff] = 1'b0;
      end
      if (wr_en) begin
         valid_in[wr_idx] = 1'b1;
      end
      if (finish && cmd_ff == slpt_pkg::CMD_RELEASE && res.found) begin
         valid_in[res.found_idx] = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         chk_ff       <= 1'b0;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         // A response taken at the edge that loads the next one stays valid.
         if (rsp_valid_ff && !rsp_stall && !finish) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               chk_ff <= 1'b0;
               cnt_ff <= '0;
               if (accept) begin
                  state_ff <= S_SCAN;
               end
            end
            S_SCAN: begin
               chk_ff     <= 1'b1;
               chk_idx_ff <= cnt_ff;
               if (cnt_ff == slpt_pkg::IDX_LAST) begin
                  state_ff <= S_DRAIN;
               end else begin
                  cnt_ff <= cnt_ff + 1'b1;
               end
            end
            S_DRAIN: begin
               chk_ff   <= 1'b0;
               state_ff <= S_FIN;
            end
            S_FIN: begin
               if (finish) begin
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff <= req_command;
         key_ff <= slpt_pkg::key_of(req_holder_key);
         rev_ff <= req_revision_in;
         dl_ff  <= req_deadline_in;
         now_ff <= req_now_time;
      end
      if (finish) begin
         hit_ff     <= hit_in;
         rev_out_ff <= rev_out_in;
         dl_out_ff  <= dl_out_in;
         removed_ff <= removed_in;
         full_ff    <= full_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_hit           = hit_ff;
   assign rsp_revision_out  = rev_out_ff;
   assign rsp_deadline_out  = dl_out_ff;
   assign rsp_removed_count = removed_ff;
   assign rsp_table_full    = full_ff;

endmodule

// ===== design/slpt_chk.sv =====
module slpt_chk (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic        rsp_hit,
   input logic [63:0] rsp_revision_out,
   input logic [4:0]  rsp_removed_count,
   input logic        rsp_table_full
);

   // A held response is not withdrawn.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("response dropped while stalled");

   // Only one request is in the table walk at a time.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second request taken during a walk");

   // A refused pin reports nothing else.
   a_full_alone: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_table_full |-> !rsp_hit && rsp_removed_count == 5'd0 &&
         rsp_revision_out == 64'd0)
      else $error("table full with other fields set");

   // An eviction count only comes with an otherwise empty response.
   a_evict_alone: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_removed_count != 5'd0 |-> !rsp_hit && !rsp_table_full &&
         rsp_revision_out == 64'd0)
      else $error("eviction count with other fields set");

   // Out of reset no response is pending.
   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind snapshot_lease_pin_table slpt_chk u_slpt_chk (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_stall         (req_stall),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_hit           (rsp_hit),
   .rsp_revision_out  (rsp_revision_out),
   .rsp_removed_count (rsp_removed_count),
   .rsp_table_full    (rsp_table_full)
);
